// File: hdl/swfrm_pkg.sv
// swfrm_pkg: shared types and constants of the sliding window frame rate meter
// action, status and register codes, controller/datapath command and status structs
// no dependencies
package swfrm_pkg;

    localparam logic [2:0] ACT_START = 3'd0;
    localparam logic [2:0] ACT_SKIP  = 3'd1;
    localparam logic [2:0] ACT_END   = 3'd2;
    localparam logic [2:0] ACT_RATE  = 3'd3;
    localparam logic [2:0] ACT_SINCE = 3'd4;
    localparam logic [2:0] ACT_CLEAR = 3'd5;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_NO_FRAME = 2'd1;
    localparam logic [1:0] ST_ALREADY  = 2'd2;
    localparam logic [1:0] ST_CLEARED  = 2'd3;

    localparam logic [0:0] CFG_MAX_AGE = 1'b0;
    localparam logic [0:0] CFG_WINDOW  = 1'b1;

    localparam logic [7:0]  MAX_AGE_RST  = 8'd20;
    localparam logic [5:0]  WINDOW_RST   = 6'd2;
    localparam logic [19:0] USEC_PER_SEC = 20'd1000000;
    localparam logic [39:0] NONE_ELAPSED = 40'd600000000;
    localparam logic [39:0] ELAPSED_MAX  = 40'hFF_FFFF_FFFF;
    localparam logic [16:0] RATE_MAX     = 17'h1FFFF;

    typedef struct packed {
        logic [31:0] sec;
        logic [19:0] usec;
        logic        skip;
    } entry_t;

    typedef struct packed {
        logic accept;
        logic exec;
        logic sel_oldest;
        logic drop_dec;
        logic walk_step;
        logic div_load;
        logic div_step;
        logic div_fin;
        logic mul;
        logic fin;
        logic load_out;
    } cmd_t;

    typedef struct packed {
        logic [2:0] action;
        logic       frame_open;
        logic       fill_zero;
        logic       drop_hit;
        logic       walk_done;
        logic       walk_found;
        logic       div_last;
    } stat_t;

endpackage

// File: hdl/swfrm_dp.sv
// swfrm_dp: datapath of the frame rate meter
// ring memory, config registers, walk counters, rate dividers, elapsed multiplier
// depends on swfrm_pkg
module swfrm_dp #(
    parameter int RING_DEPTH = 256
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  swfrm_pkg::cmd_t     cmd,
    output swfrm_pkg::stat_t    stat,
    input  logic                cfg_we,
    input  logic [0:0]          cfg_index,
    input  logic [7:0]          cfg_data,
    input  logic [2:0]          s_action,
    input  logic [31:0]         s_now_sec,
    input  logic [19:0]         s_now_usec,
    input  logic                s_only_unskipped,
    output logic [1:0]          m_status,
    output logic [8:0]          m_frame_count,
    output logic [8:0]          m_skipped_count,
    output logic [16:0]         m_frame_rate,
    output logic [16:0]         m_skipped_rate,
    output logic [39:0]         m_elapsed_us
);

    localparam int AW  = $clog2(RING_DEPTH);
    localparam int FW  = $clog2(RING_DEPTH + 1);
    localparam int QW  = FW + 8;
    localparam int QXW = (QW > 18) ? QW : 18;
    localparam int EXW = (FW > 9) ? FW : 9;
    localparam int IW  = $clog2(QW + 1);
    localparam int OW  = AW + 2;
    localparam logic [AW-1:0] LAST_SLOT = AW'(RING_DEPTH - 1);
    localparam logic [FW-1:0] FILL_MAX  = FW'(RING_DEPTH);
    localparam logic [OW-1:0] DEPTH_W   = OW'(RING_DEPTH);

    swfrm_pkg::entry_t ring_mem [RING_DEPTH];
    swfrm_pkg::entry_t rd_reg;

    logic [7:0]  max_age_reg;
    logic [5:0]  window_reg;
    logic [2:0]  act_reg;
    logic [31:0] nsec_reg;
    logic [19:0] nusec_reg;
    logic        only_reg;

    logic [AW-1:0] head_reg;
    logic [FW-1:0] fill_reg;
    logic          open_reg;
    logic          oskip_reg;

    logic [AW-1:0] ptr_reg;
    logic [FW-1:0] left_reg;
    logic          pend_reg;
    logic [FW-1:0] nf_reg;
    logic [FW-1:0] ns_reg;
    logic [31:0]   es_reg;
    logic [19:0]   eus_reg;
    logic signed [53:0] prod_reg;

    logic [QW-1:0] dq_f_reg;
    logic [QW-1:0] dq_s_reg;
    logic [6:0]    rem_f_reg;
    logic [6:0]    rem_s_reg;
    logic [IW-1:0] iter_reg;

    logic [1:0]  res_status_reg;
    logic [8:0]  res_fc_reg;
    logic [8:0]  res_sc_reg;
    logic [16:0] res_fr_reg;
    logic [16:0] res_sr_reg;
    logic [39:0] res_el_reg;

    logic [1:0]  m_status_reg;
    logic [8:0]  m_fc_reg;
    logic [8:0]  m_sc_reg;
    logic [16:0] m_fr_reg;
    logic [16:0] m_sr_reg;
    logic [39:0] m_el_reg;

    logic signed [33:0] since_sec;
    logic signed [33:0] drop_limit;
    logic signed [33:0] es_s;
    logic               stop_rate;
    logic               in_window;
    logic               match_since;
    logic               is_rate;
    logic               walk_stop;
    logic               end_ok;
    logic [OW-1:0]      old_sum;
    logic [AW-1:0]      old_idx;
    logic [AW-1:0]      rd_addr;
    logic [AW-1:0]      head_inc;
    logic [AW-1:0]      ptr_dec;
    logic [AW-1:0]      ptr_init;
    logic [6:0]         rsh_f;
    logic [6:0]         rsh_s;
    logic               ge_f;
    logic               ge_s;
    logic [QXW-1:0]     qx_f;
    logic [QXW-1:0]     qx_s;
    logic [EXW-1:0]     nf_x;
    logic [EXW-1:0]     ns_x;
    logic signed [32:0] dsec;
    logic signed [20:0] dusec;
    logic signed [53:0] prod_next;
    logic signed [54:0] dsum;

    // window and age limits
    assign since_sec  = $signed({2'b00, nsec_reg}) - $signed({28'd0, window_reg});
    assign drop_limit = $signed({2'b00, nsec_reg}) - $signed({26'd0, max_age_reg});
    assign es_s       = $signed({2'b00, rd_reg.sec});

    assign stop_rate   = es_s < since_sec;
    assign in_window   = (es_s > since_sec) || (rd_reg.usec >= nusec_reg);
    assign match_since = !(only_reg && rd_reg.skip);
    assign is_rate     = act_reg == swfrm_pkg::ACT_RATE;
    assign walk_stop   = pend_reg && (is_rate ? stop_rate : match_since);
    assign end_ok      = (act_reg == swfrm_pkg::ACT_END) && open_reg;

    // ring slot arithmetic
    assign old_sum  = OW'(head_reg) + DEPTH_W - OW'(fill_reg);
    assign old_idx  = (old_sum >= DEPTH_W) ? AW'(old_sum - DEPTH_W) : AW'(old_sum);
    assign rd_addr  = cmd.sel_oldest ? old_idx : ptr_reg;
    assign head_inc = (head_reg == LAST_SLOT) ? '0 : head_reg + AW'(1);
    assign ptr_dec  = (ptr_reg == '0) ? LAST_SLOT : ptr_reg - AW'(1);
    assign ptr_init = (head_reg == '0) ? LAST_SLOT : head_reg - AW'(1);

    // divider steps
    assign rsh_f = {rem_f_reg[5:0], dq_f_reg[QW-1]};
    assign rsh_s = {rem_s_reg[5:0], dq_s_reg[QW-1]};
    assign ge_f  = rsh_f >= {1'b0, window_reg};
    assign ge_s  = rsh_s >= {1'b0, window_reg};
    assign qx_f  = QXW'(dq_f_reg);
    assign qx_s  = QXW'(dq_s_reg);
    assign nf_x  = EXW'(nf_reg);
    assign ns_x  = EXW'(ns_reg);

    // elapsed time
    assign dsec      = $signed({1'b0, nsec_reg}) - $signed({1'b0, es_reg});
    assign prod_next = dsec * $signed({1'b0, swfrm_pkg::USEC_PER_SEC});
    assign dusec     = $signed({1'b0, nusec_reg}) - $signed({1'b0, eus_reg});
    assign dsum      = 55'(prod_reg) + 55'(dusec);

    assign stat.action     = act_reg;
    assign stat.frame_open = open_reg;
    assign stat.fill_zero  = fill_reg == '0;
    assign stat.drop_hit   = es_s < drop_limit;
    assign stat.walk_done  = walk_stop || (!pend_reg && left_reg == '0);
    assign stat.walk_found = walk_stop;
    assign stat.div_last   = iter_reg == IW'(1);

    // ring memory
    always_ff @(posedge aclk) begin
        if (cmd.exec && end_ok) begin
            ring_mem[head_reg] <= '{sec: nsec_reg, usec: nusec_reg, skip: oskip_reg};
        end
        rd_reg <= ring_mem[rd_addr];
    end

    // control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            max_age_reg <= swfrm_pkg::MAX_AGE_RST;
            window_reg  <= swfrm_pkg::WINDOW_RST;
            head_reg    <= '0;
            fill_reg    <= '0;
            open_reg    <= 1'b0;
            oskip_reg   <= 1'b0;
            pend_reg    <= 1'b0;
        end else begin
            if (cfg_we) begin
                unique case (cfg_index)
                    swfrm_pkg::CFG_MAX_AGE: max_age_reg <= cfg_data;
                    swfrm_pkg::CFG_WINDOW:  window_reg  <= cfg_data[5:0];
                    default: ;
                endcase
            end
            if (cmd.exec) begin
                pend_reg <= 1'b0;
                unique case (act_reg)
                    swfrm_pkg::ACT_START: begin
                        if (!open_reg) begin
                            open_reg  <= 1'b1;
                            oskip_reg <= 1'b0;
                        end
                    end
                    swfrm_pkg::ACT_SKIP: begin
                        if (open_reg) begin
                            oskip_reg <= 1'b1;
                        end
                    end
                    swfrm_pkg::ACT_END: begin
                        if (open_reg) begin
                            head_reg  <= head_inc;
                            fill_reg  <= (fill_reg < FILL_MAX) ? fill_reg + FW'(1) : fill_reg;
                            open_reg  <= 1'b0;
                            oskip_reg <= 1'b0;
                        end
                    end
                    swfrm_pkg::ACT_CLEAR: begin
                        open_reg  <= 1'b0;
                        oskip_reg <= 1'b0;
                        fill_reg  <= '0;
                        head_reg  <= '0;
                    end
                    default: ;
                endcase
            end
            if (cmd.drop_dec && stat.drop_hit) begin
                fill_reg <= fill_reg - FW'(1);
            end
            if (cmd.walk_step) begin
                pend_reg <= !walk_stop && (left_reg != '0);
            end
        end
    end

    // item, walk and arithmetic registers
    always_ff @(posedge aclk) begin
        if (cmd.accept) begin
            act_reg   <= s_action;
            nsec_reg  <= s_now_sec;
            nusec_reg <= s_now_usec;
            only_reg  <= s_only_unskipped;
        end
        if (cmd.exec) begin
            ptr_reg        <= ptr_init;
            left_reg       <= fill_reg;
            nf_reg         <= '0;
            ns_reg         <= '0;
            res_fc_reg     <= '0;
            res_sc_reg     <= '0;
            res_fr_reg     <= '0;
            res_sr_reg     <= '0;
            res_el_reg     <= (act_reg == swfrm_pkg::ACT_SINCE) ? swfrm_pkg::NONE_ELAPSED : '0;
            unique case (act_reg)
                swfrm_pkg::ACT_START: begin
                    res_status_reg <= open_reg ? swfrm_pkg::ST_ALREADY : swfrm_pkg::ST_OK;
                end
                swfrm_pkg::ACT_SKIP, swfrm_pkg::ACT_END: begin
                    res_status_reg <= open_reg ? swfrm_pkg::ST_OK : swfrm_pkg::ST_NO_FRAME;
                end
                swfrm_pkg::ACT_CLEAR: begin
                    res_status_reg <= open_reg ? swfrm_pkg::ST_CLEARED : swfrm_pkg::ST_OK;
                end
                default: begin
                    res_status_reg <= swfrm_pkg::ST_OK;
                end
            endcase
        end
        if (cmd.walk_step) begin
            if (pend_reg && is_rate && !stop_rate && in_window) begin
                if (rd_reg.skip) begin
                    ns_reg <= ns_reg + FW'(1);
                end else begin
                    nf_reg <= nf_reg + FW'(1);
                end
            end
            if (walk_stop && !is_rate) begin
                es_reg  <= rd_reg.sec;
                eus_reg <= rd_reg.usec;
            end
            if (!walk_stop && left_reg != '0) begin
                ptr_reg  <= ptr_dec;
                left_reg <= left_reg - FW'(1);
            end
        end
        if (cmd.div_load) begin
            dq_f_reg  <= {nf_reg, 8'd0} + QW'(window_reg[5:1]);
            dq_s_reg  <= {ns_reg, 8'd0} + QW'(window_reg[5:1]);
            rem_f_reg <= '0;
            rem_s_reg <= '0;
            iter_reg  <= IW'(QW);
        end
        if (cmd.div_step) begin
            rem_f_reg <= ge_f ? rsh_f - {1'b0, window_reg} : rsh_f;
            rem_s_reg <= ge_s ? rsh_s - {1'b0, window_reg} : rsh_s;
            dq_f_reg  <= {dq_f_reg[QW-2:0], ge_f};
            dq_s_reg  <= {dq_s_reg[QW-2:0], ge_s};
            iter_reg  <= iter_reg - IW'(1);
        end
        if (cmd.div_fin) begin
            res_fc_reg <= nf_x[8:0];
            res_sc_reg <= ns_x[8:0];
            if (window_reg == '0) begin
                res_fr_reg <= '0;
                res_sr_reg <= '0;
            end else begin
                res_fr_reg <= (qx_f > QXW'(swfrm_pkg::RATE_MAX)) ? swfrm_pkg::RATE_MAX
                                                                 : qx_f[16:0];
                res_sr_reg <= (qx_s > QXW'(swfrm_pkg::RATE_MAX)) ? swfrm_pkg::RATE_MAX
                                                                 : qx_s[16:0];
            end
        end
        if (cmd.mul) begin
            prod_reg <= prod_next;
        end
        if (cmd.fin) begin
            if (dsum < 0) begin
                res_el_reg <= '0;
            end else if (dsum[54:40] != '0) begin
                res_el_reg <= swfrm_pkg::ELAPSED_MAX;
            end else begin
                res_el_reg <= dsum[39:0];
            end
        end
        if (cmd.load_out) begin
            m_status_reg <= res_status_reg;
            m_fc_reg     <= res_fc_reg;
            m_sc_reg     <= res_sc_reg;
            m_fr_reg     <= res_fr_reg;
            m_sr_reg     <= res_sr_reg;
            m_el_reg     <= res_el_reg;
        end
    end

    assign m_status        = m_status_reg;
    assign m_frame_count   = m_fc_reg;
    assign m_skipped_count = m_sc_reg;
    assign m_frame_rate    = m_fr_reg;
    assign m_skipped_rate  = m_sr_reg;
    assign m_elapsed_us    = m_el_reg;

    a_fill_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        fill_reg <= FILL_MAX)
        else $error("ring fill beyond depth");

    a_head_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        head_reg <= LAST_SLOT)
        else $error("ring head out of range");

endmodule

// File: hdl/swfrm_ctrl.sv
// swfrm_ctrl: sequencing state machine of the frame rate meter
// drives datapath commands from its status, owns input ready and output valid
// depends on swfrm_pkg
module swfrm_ctrl (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    output logic              m_valid,
    input  logic              m_ready,
    output swfrm_pkg::cmd_t   cmd,
    input  swfrm_pkg::stat_t  stat
);

    typedef enum logic [10:0] {
        ST_IDLE     = 11'b000_0000_0001,
        ST_EXEC     = 11'b000_0000_0010,
        ST_DROP_RD  = 11'b000_0000_0100,
        ST_DROP_CHK = 11'b000_0000_1000,
        ST_WALK     = 11'b000_0001_0000,
        ST_DIV_LD   = 11'b000_0010_0000,
        ST_DIV      = 11'b000_0100_0000,
        ST_DIV_FIN  = 11'b000_1000_0000,
        ST_MUL      = 11'b001_0000_0000,
        ST_FIN      = 11'b010_0000_0000,
        ST_OUT      = 11'b100_0000_0000
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   m_valid_reg;
    logic   m_valid_next;
    logic   out_free;

    assign out_free = !m_valid_reg || m_ready;

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            ST_IDLE: begin
                cmd.accept = s_valid;
                if (s_valid) state_next = ST_EXEC;
            end
            ST_EXEC: begin
                cmd.exec = 1'b1;
                priority if (stat.action == swfrm_pkg::ACT_END && stat.frame_open) begin
                    state_next = ST_DROP_RD;
                end else if (stat.action == swfrm_pkg::ACT_RATE ||
                             stat.action == swfrm_pkg::ACT_SINCE) begin
                    state_next = ST_WALK;
                end else begin
                    state_next = ST_OUT;
                end
            end
            ST_DROP_RD: begin
                cmd.sel_oldest = 1'b1;
                state_next = stat.fill_zero ? ST_OUT : ST_DROP_CHK;
            end
            ST_DROP_CHK: begin
                cmd.drop_dec = 1'b1;
                state_next = stat.drop_hit ? ST_DROP_RD : ST_OUT;
            end
            ST_WALK: begin
                cmd.walk_step = 1'b1;
                if (stat.walk_done) begin
                    priority if (stat.action == swfrm_pkg::ACT_RATE) begin
                        state_next = ST_DIV_LD;
                    end else if (stat.walk_found) begin
                        state_next = ST_MUL;
                    end else begin
                        state_next = ST_OUT;
                    end
                end
            end
            ST_DIV_LD: begin
                cmd.div_load = 1'b1;
                state_next = ST_DIV;
            end
            ST_DIV: begin
                cmd.div_step = 1'b1;
                if (stat.div_last) state_next = ST_DIV_FIN;
            end
            ST_DIV_FIN: begin
                cmd.div_fin = 1'b1;
                state_next = ST_OUT;
            end
            ST_MUL: begin
                cmd.mul = 1'b1;
                state_next = ST_FIN;
            end
            ST_FIN: begin
                cmd.fin = 1'b1;
                state_next = ST_OUT;
            end
            ST_OUT: begin
                cmd.load_out = out_free;
                if (out_free) state_next = ST_IDLE;
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        m_valid_next = m_valid_reg;
        priority if (cmd.load_out) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    assign s_ready = state_reg == ST_IDLE;
    assign m_valid = m_valid_reg;

    a_accept_exec: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> state_reg == ST_EXEC)
        else $error("accepted transaction not executed");

    a_out_load: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.load_out |-> (!m_valid_reg || m_ready))
        else $error("output register overwritten while held");

    a_rate_div: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_WALK && stat.walk_done && stat.action == swfrm_pkg::ACT_RATE
        |=> state_reg == ST_DIV_LD)
        else $error("rate query skipped the divider");

endmodule

// File: hdl/sliding_window_frame_rate_meter.sv
// sliding_window_frame_rate_meter: top level of the frame rate meter
// joins swfrm_ctrl and swfrm_dp; depends on swfrm_pkg
//
//   channel  direction  ports
//   cfg      in         cfg_we, cfg_index, cfg_data (write only)
//   s_       in         s_valid/s_ready, s_action, s_now_sec, s_now_usec, s_only_unskipped
//   m_       out        m_valid/m_ready, status, counts, rates, elapsed_us
//
// one transaction at a time: start, skip, clear and unused codes run accept, execute, output
// end with an open frame adds a read and age check of the oldest entry until one is kept or the ring empties
// queries walk the ring from the newest entry at one entry per cycle;
// since adds a multiply and a finish step when a frame is found, rate adds a serial divider
// synchronous active-low reset clears control state; a held result stalls the next
// transaction only at its output step
module sliding_window_frame_rate_meter #(
    parameter int RING_DEPTH = 256
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_we,
    input  logic [0:0]  cfg_index,
    input  logic [7:0]  cfg_data,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [2:0]  s_action,
    input  logic [31:0] s_now_sec,
    input  logic [19:0] s_now_usec,
    input  logic        s_only_unskipped,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [1:0]  m_status,
    output logic [8:0]  m_frame_count,
    output logic [8:0]  m_skipped_count,
    output logic [16:0] m_frame_rate,
    output logic [16:0] m_skipped_rate,
    output logic [39:0] m_elapsed_us
);

    swfrm_pkg::cmd_t  cmd;
    swfrm_pkg::stat_t stat;

    swfrm_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .cmd     (cmd),
        .stat    (stat)
    );

    swfrm_dp #(
        .RING_DEPTH (RING_DEPTH)
    ) u_dp (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .cmd              (cmd),
        .stat             (stat),
        .cfg_we           (cfg_we),
        .cfg_index        (cfg_index),
        .cfg_data         (cfg_data),
        .s_action         (s_action),
        .s_now_sec        (s_now_sec),
        .s_now_usec       (s_now_usec),
        .s_only_unskipped (s_only_unskipped),
        .m_status         (m_status),
        .m_frame_count    (m_frame_count),
        .m_skipped_count  (m_skipped_count),
        .m_frame_rate     (m_frame_rate),
        .m_skipped_rate   (m_skipped_rate),
        .m_elapsed_us     (m_elapsed_us)
    );

endmodule

// File: verif/tb.sv
`timescale 1ns / 1ps
// tb: self-checking testbench for sliding_window_frame_rate_meter
// sends frame, query and clear transactions with random gaps, predicts every reading in-bench
// depends on swfrm_pkg and the meter rtl
module tb;

    localparam int DEPTH = 256;
    localparam int STALL_LIMIT = 5000;
    localparam logic [2:0] ACT_SPARE_A = 3'd6;
    localparam logic [2:0] ACT_SPARE_B = 3'd7;

    typedef struct packed {
        logic [1:0]  status;
        logic [8:0]  frame_count;
        logic [8:0]  skipped_count;
        logic [16:0] frame_rate;
        logic [16:0] skipped_rate;
        logic [39:0] elapsed_us;
    } reading_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        cfg_we = 1'b0;
    logic [0:0]  cfg_index = '0;
    logic [7:0]  cfg_data = '0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    logic [2:0]  s_action = '0;
    logic [31:0] s_now_sec = '0;
    logic [19:0] s_now_usec = '0;
    logic        s_only_unskipped = 1'b0;
    logic        m_valid;
    logic        m_ready = 1'b1;
    logic [1:0]  m_status;
    logic [8:0]  m_frame_count;
    logic [8:0]  m_skipped_count;
    logic [16:0] m_frame_rate;
    logic [16:0] m_skipped_rate;
    logic [39:0] m_elapsed_us;

    // predictor state
    logic [31:0] ring_sec [DEPTH];
    logic [19:0] ring_usec [DEPTH];
    logic        ring_skip [DEPTH];
    int          ring_head = 0;
    int          ring_fill = 0;
    bit          frame_is_open = 1'b0;
    bit          frame_marked_skip = 1'b0;
    int          cfg_max_age = int'(swfrm_pkg::MAX_AGE_RST);
    int          cfg_window = int'(swfrm_pkg::WINDOW_RST);

    reading_t    pending_readings[$];
    int          mismatch_count = 0;
    int          items_sent = 0;
    int unsigned quiet_cycles = 0;
    int unsigned sink_hold = 0;
    bit          src_idle = 1'b1;
    bit          sink_idle = 1'b1;
    logic [31:0] now_s = '0;
    logic [19:0] now_us = '0;

    sliding_window_frame_rate_meter #(.RING_DEPTH(DEPTH)) DUT (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .cfg_we           (cfg_we),
        .cfg_index        (cfg_index),
        .cfg_data         (cfg_data),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_action         (s_action),
        .s_now_sec        (s_now_sec),
        .s_now_usec       (s_now_usec),
        .s_only_unskipped (s_only_unskipped),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_status         (m_status),
        .m_frame_count    (m_frame_count),
        .m_skipped_count  (m_skipped_count),
        .m_frame_rate     (m_frame_rate),
        .m_skipped_rate   (m_skipped_rate),
        .m_elapsed_us     (m_elapsed_us)
    );

    always #1 aclk = ~aclk;

    function automatic logic [16:0] to_rate(input int count, input int win);
        longint q;
        if (win == 0) begin
            return '0;
        end
        q = (longint'(count) * 256 + win / 2) / win;
        return (q > longint'(swfrm_pkg::RATE_MAX)) ? swfrm_pkg::RATE_MAX : q[16:0];
    endfunction

    function automatic reading_t compute_reading(input logic [2:0] act, input logic [31:0] sec,
                                                 input logic [19:0] usec, input logic only);
        reading_t r;
        longint   now_l;
        longint   bound;
        longint   es;
        longint   d;
        int       nf;
        int       ns;
        int       k;
        int       slot;
        bit       walking;
        r = '0;
        now_l = $signed({32'd0, sec});
        case (act)
            swfrm_pkg::ACT_START: begin
                if (frame_is_open) begin
                    r.status = swfrm_pkg::ST_ALREADY;
                end else begin
                    frame_is_open = 1'b1;
                    frame_marked_skip = 1'b0;
                end
            end
            swfrm_pkg::ACT_SKIP: begin
                if (!frame_is_open) begin
                    r.status = swfrm_pkg::ST_NO_FRAME;
                end else begin
                    frame_marked_skip = 1'b1;
                end
            end
            swfrm_pkg::ACT_END: begin
                if (!frame_is_open) begin
                    r.status = swfrm_pkg::ST_NO_FRAME;
                end else begin
                    ring_sec[ring_head] = sec;
                    ring_usec[ring_head] = usec;
                    ring_skip[ring_head] = frame_marked_skip;
                    ring_head = (ring_head + 1) % DEPTH;
                    if (ring_fill < DEPTH) begin
                        ring_fill++;
                    end
                    frame_is_open = 1'b0;
                    frame_marked_skip = 1'b0;
                    // expire from the oldest end
                    bound = now_l - longint'(cfg_max_age);
                    walking = 1'b1;
                    while (ring_fill > 0 && walking) begin
                        es = $signed({32'd0, ring_sec[(ring_head + DEPTH - ring_fill) % DEPTH]});
                        if (es < bound) begin
                            ring_fill--;
                        end else begin
                            walking = 1'b0;
                        end
                    end
                end
            end
            swfrm_pkg::ACT_RATE: begin
                bound = now_l - longint'(cfg_window);
                nf = 0;
                ns = 0;
                walking = 1'b1;
                for (k = 0; k < ring_fill && walking; k++) begin
                    slot = (ring_head + 2 * DEPTH - 1 - k) % DEPTH;
                    es = $signed({32'd0, ring_sec[slot]});
                    if (es < bound) begin
                        walking = 1'b0;
                    end else if (es > bound || ring_usec[slot] >= usec) begin
                        if (ring_skip[slot]) begin
                            ns++;
                        end else begin
                            nf++;
                        end
                    end
                end
                r.frame_count = nf[8:0];
                r.skipped_count = ns[8:0];
                r.frame_rate = to_rate(nf, cfg_window);
                r.skipped_rate = to_rate(ns, cfg_window);
            end
            swfrm_pkg::ACT_SINCE: begin
                r.elapsed_us = swfrm_pkg::NONE_ELAPSED;
                walking = 1'b1;
                for (k = 0; k < ring_fill && walking; k++) begin
                    slot = (ring_head + 2 * DEPTH - 1 - k) % DEPTH;
                    if (!(only && ring_skip[slot])) begin
                        walking = 1'b0;
                        es = $signed({32'd0, ring_sec[slot]});
                        d = (now_l - es) * longint'(swfrm_pkg::USEC_PER_SEC)
                            + (longint'(usec) - longint'(ring_usec[slot]));
                        if (d < 0) begin
                            r.elapsed_us = '0;
                        end else if (d > longint'(swfrm_pkg::ELAPSED_MAX)) begin
                            r.elapsed_us = swfrm_pkg::ELAPSED_MAX;
                        end else begin
                            r.elapsed_us = d[39:0];
                        end
                    end
                end
            end
            swfrm_pkg::ACT_CLEAR: begin
                if (frame_is_open) begin
                    r.status = swfrm_pkg::ST_CLEARED;
                end
                frame_is_open = 1'b0;
                frame_marked_skip = 1'b0;
                ring_fill = 0;
                ring_head = 0;
            end
            default: begin
            end
        endcase
        return r;
    endfunction

    task automatic report_mismatch(input string what, input longint unsigned got,
                                   input longint unsigned want);
        if (mismatch_count < 40) begin
            $display("%0t: %s: got %0d, expected %0d", $realtime, what, got, want);
        end
        mismatch_count++;
    endtask

    task automatic send_item(input logic [2:0] act, input logic [31:0] sec,
                             input logic [19:0] usec, input logic only);
        int unsigned gap;
        gap = src_idle ? $urandom_range(0, 17) : 0;
        if (gap != 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_action <= act;
        s_now_sec <= sec;
        s_now_usec <= usec;
        s_only_unskipped <= only;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        pending_readings.push_back(compute_reading(act, sec, usec, only));
        items_sent++;
    endtask

    task automatic finish_phase();
        s_valid <= 1'b0;
        while (pending_readings.size() != 0) @(posedge aclk);
        repeat (16) @(posedge aclk);
    endtask

    task automatic set_config(input int age, input int win);
        finish_phase();
        cfg_we <= 1'b1;
        cfg_index <= swfrm_pkg::CFG_MAX_AGE;
        cfg_data <= age[7:0];
        @(posedge aclk);
        cfg_index <= swfrm_pkg::CFG_WINDOW;
        cfg_data <= {2'b00, win[5:0]};
        @(posedge aclk);
        cfg_we <= 1'b0;
        cfg_max_age = age;
        cfg_window = win;
    endtask

    function automatic void advance_clock(input int unsigned step_max);
        longint total;
        total = longint'(now_us) + longint'($urandom_range(0, step_max));
        now_s = now_s + 32'(total / longint'(swfrm_pkg::USEC_PER_SEC));
        now_us = 20'(total % longint'(swfrm_pkg::USEC_PER_SEC));
    endfunction

    task automatic run_traffic(input int n_items, input int unsigned step_max, input int noise_pct,
                               input int query_pct, input bit allow_clear);
        int          stop_at;
        int          roll;
        logic [2:0]  act;
        logic [31:0] qsec;
        stop_at = items_sent + n_items;
        while (items_sent < stop_at) begin
            if ($urandom_range(0, 31) == 0) src_idle = ~src_idle;
            if ($urandom_range(0, 31) == 0) sink_idle = ~sink_idle;
            roll = $urandom_range(0, 99);
            if (roll < noise_pct) begin
                act = 3'($urandom_range(0, 7));
                if (act == swfrm_pkg::ACT_CLEAR && !allow_clear) begin
                    act = ACT_SPARE_A;
                end
                if ($urandom_range(0, 1) == 1) begin
                    send_item(act, $urandom, 20'($urandom_range(0, 999999)),
                              1'($urandom_range(0, 1)));
                end else begin
                    send_item(act, now_s, now_us, 1'($urandom_range(0, 1)));
                end
            end else if (roll < noise_pct + query_pct) begin
                // probe around the window boundary, sometimes behind the newest frame
                qsec = now_s + $urandom_range(0, cfg_window + 1);
                if ($urandom_range(0, 9) == 0) begin
                    qsec = now_s - 32'd1;
                end
                act = ($urandom_range(0, 1) == 1) ? swfrm_pkg::ACT_RATE : swfrm_pkg::ACT_SINCE;
                send_item(act, qsec, 20'($urandom_range(0, 999999)), 1'($urandom_range(0, 1)));
            end else begin
                advance_clock(step_max);
                send_item(swfrm_pkg::ACT_START, now_s, now_us, 1'($urandom_range(0, 1)));
                if ($urandom_range(0, 99) < 15) begin
                    advance_clock(step_max);
                    send_item(swfrm_pkg::ACT_SKIP, now_s, now_us, 1'($urandom_range(0, 1)));
                end
                advance_clock(step_max);
                send_item(swfrm_pkg::ACT_END, now_s, now_us, 1'($urandom_range(0, 1)));
            end
        end
    endtask

    task automatic test_protocol_errors();
        send_item(swfrm_pkg::ACT_SKIP, 32'd0, 20'd0, 1'b0);
        send_item(swfrm_pkg::ACT_END, 32'd0, 20'd0, 1'b1);
        send_item(swfrm_pkg::ACT_SINCE, 32'd1, 20'd0, 1'b0);
        send_item(ACT_SPARE_A, $urandom, 20'($urandom_range(0, 999999)), 1'b1);
        send_item(ACT_SPARE_B, $urandom, 20'($urandom_range(0, 999999)), 1'b0);
    endtask

    task automatic test_window_edges();
        send_item(swfrm_pkg::ACT_START, 32'd100, 20'd0, 1'b0);
        send_item(swfrm_pkg::ACT_SKIP, 32'd100, 20'd200000, 1'b0);
        send_item(swfrm_pkg::ACT_END, 32'd100, 20'd500000, 1'b0);
        send_item(swfrm_pkg::ACT_START, 32'd101, 20'd0, 1'b0);
        send_item(swfrm_pkg::ACT_END, 32'd101, 20'd250000, 1'b0);
        // oldest frame sits exactly on the window start second
        send_item(swfrm_pkg::ACT_RATE, 32'd102, 20'd250000, 1'b0);
        send_item(swfrm_pkg::ACT_RATE, 32'd102, 20'd500001, 1'b0);
        send_item(swfrm_pkg::ACT_START, 32'd101, 20'd600000, 1'b0);
        send_item(swfrm_pkg::ACT_START, 32'd101, 20'd700000, 1'b0);
        send_item(swfrm_pkg::ACT_SKIP, 32'd101, 20'd800000, 1'b0);
        send_item(swfrm_pkg::ACT_END, 32'd101, 20'd900000, 1'b0);
        send_item(swfrm_pkg::ACT_SINCE, 32'd102, 20'd0, 1'b1);
        send_item(swfrm_pkg::ACT_SINCE, 32'd102, 20'd0, 1'b0);
    endtask

    task automatic test_time_extremes();
        set_config(255, 63);
        send_item(swfrm_pkg::ACT_START, 32'd0, 20'd0, 1'b0);
        send_item(swfrm_pkg::ACT_END, 32'd0, 20'd0, 1'b0);
        send_item(swfrm_pkg::ACT_SINCE, 32'hFFFF_FFFF, 20'd999999, 1'b0);
        // window reaches back before time zero
        send_item(swfrm_pkg::ACT_RATE, 32'd5, 20'd0, 1'b1);
        send_item(swfrm_pkg::ACT_START, 32'hFFFF_FFFF, 20'd999999, 1'b1);
        send_item(swfrm_pkg::ACT_END, 32'hFFFF_FFFF, 20'd999999, 1'b1);
        send_item(swfrm_pkg::ACT_SINCE, 32'd0, 20'd0, 1'b1);
    endtask

    task automatic test_zero_window();
        set_config(1, 0);
        send_item(swfrm_pkg::ACT_RATE, 32'hFFFF_FFFF, 20'd999999, 1'b0);
        send_item(swfrm_pkg::ACT_START, 32'd7, 20'd0, 1'b0);
        send_item(swfrm_pkg::ACT_CLEAR, 32'd7, 20'd1, 1'b0);
    endtask

    task automatic test_mixed_traffic();
        set_config($urandom_range(1, 255), $urandom_range(1, 63));
        now_s = $urandom;
        now_us = 20'($urandom_range(0, 999999));
        run_traffic(40, 400000, 10, 20, 1'b1);
    endtask

    task automatic test_full_ring();
        set_config(255, 63);
        now_s = $urandom;
        now_us = 20'($urandom_range(0, 999999));
        run_traffic(600, 2000, 1, 3, 1'b0);
    endtask

    task automatic test_fast_expiry();
        set_config(1, 1);
        now_s = $urandom;
        now_us = 20'($urandom_range(0, 999999));
        run_traffic(40, 1500000, 10, 25, 1'b1);
    endtask

    always @(posedge aclk) begin : score_readings
        reading_t want;
        if (aresetn && m_valid && m_ready) begin
            if (pending_readings.size() == 0) begin
                report_mismatch("reading with no transaction pending", 64'(m_status), 64'd0);
            end else begin
                want = pending_readings.pop_front();
                if (m_status !== want.status)
                    report_mismatch("status", 64'(m_status), 64'(want.status));
                if (m_frame_count !== want.frame_count)
                    report_mismatch("frame_count", 64'(m_frame_count),
                                    64'(want.frame_count));
                if (m_skipped_count !== want.skipped_count)
                    report_mismatch("skipped_count", 64'(m_skipped_count),
                                    64'(want.skipped_count));
                if (m_frame_rate !== want.frame_rate)
                    report_mismatch("frame_rate", 64'(m_frame_rate), 64'(want.frame_rate));
                if (m_skipped_rate !== want.skipped_rate)
                    report_mismatch("skipped_rate", 64'(m_skipped_rate),
                                    64'(want.skipped_rate));
                if (m_elapsed_us !== want.elapsed_us)
                    report_mismatch("elapsed_us", 64'(m_elapsed_us), 64'(want.elapsed_us));
            end
        end
    end

    // result side back-pressure, redrawn after each transaction
    always @(posedge aclk) begin
        if (m_valid && m_ready) begin
            sink_hold = sink_idle ? $urandom_range(0, 17) : 0;
            m_ready <= (sink_hold == 0);
        end else if (sink_hold != 0) begin
            sink_hold = sink_hold - 1;
            m_ready <= (sink_hold == 0);
        end
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready)) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles = quiet_cycles + 1;
            if (quiet_cycles >= STALL_LIMIT) begin
                $display("SCOREBOARD MISMATCH");
                $finish;
            end
        end
    end

    initial begin
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_protocol_errors();
        test_window_edges();
        test_time_extremes();
        test_zero_window();
        test_mixed_traffic();
        test_full_ring();
        test_fast_expiry();
        finish_phase();
        if (mismatch_count == 0 && pending_readings.size() == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule
